/* sv/psvd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the program stream video demux.
// No dependencies; every other file imports this package.
package psvd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PTS_W   = 33;
	localparam int unsigned POS_W   = 17;
	localparam int unsigned HDR_W   = 9;
	localparam int unsigned RECENT_W = 24;

	// Stream ids and header constants
	localparam logic [7:0] ID_PACK      = 8'hBA;
	localparam logic [7:0] ID_PROG_END  = 8'hB9;
	localparam logic [7:0] ID_FIRST_LEN = 8'hBB;
	localparam logic [7:0] ID_VIDEO_LO  = 8'hE0;
	localparam logic [7:0] ID_VIDEO_HI  = 8'hEF;
	localparam logic [7:0] MPEG2_MASK   = 8'hC0;
	localparam logic [7:0] MPEG2_MARK   = 8'h80;

	localparam logic [RECENT_W-1:0] START_CODE  = 24'h000001;
	localparam logic [RECENT_W-1:0] RECENT_IDLE = 24'hFFFFFF;

	// Byte positions inside an element
	localparam logic [POS_W-1:0] POS_CODE_DONE = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd5;
	localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd6;
	localparam logic [POS_W-1:0] POS_HDR_FLAGS = 17'd7;
	localparam logic [POS_W-1:0] POS_HDR_LEN   = 17'd8;
	localparam logic [POS_W-1:0] POS_PTS_0     = 17'd9;
	localparam logic [POS_W-1:0] POS_PTS_1     = 17'd10;
	localparam logic [POS_W-1:0] POS_PTS_2     = 17'd11;
	localparam logic [POS_W-1:0] POS_PTS_3     = 17'd12;
	localparam logic [POS_W-1:0] POS_PTS_4     = 17'd13;
	localparam logic [POS_W-1:0] PACK_LEN      = 17'd14;
	localparam logic [POS_W-1:0] PES_HDR_BYTES = 17'd6;
	localparam logic [POS_W-1:0] MIN_VIDEO_LEN = 17'd9;
	localparam logic [POS_W-1:0] MIN_PTS_LEN   = 17'd14;
	localparam logic [7:0]       MIN_PTS_HDR   = 8'd5;
	localparam logic [HDR_W-1:0] HDR_BASE      = 9'd9;

	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_CODE   = 5'b00010,
		PH_LEN_HI = 5'b00100,
		PH_LEN_LO = 5'b01000,
		PH_BODY   = 5'b10000
	} psvd_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              chunk_first;
		logic              chunk_last;
		logic              pts_present;
		logic [PTS_W-1:0]  pts;
	} psvd_result_t;

endpackage

/* sv/psvd_parser.sv */
`timescale 1ns / 1ps
// Start code hunter and PES parser: holds the parse state, advances it by one
// byte per step and flags a payload byte. Depends on psvd_pkg.
module psvd_parser import psvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [BYTE_W-1:0]  byte_in,
	output logic               emit,
	output psvd_result_t       result
);

	psvd_phase_t         phase_q, phase_d;
	logic [RECENT_W-1:0] recent_q, recent_d;
	logic [7:0]          code_q, code_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [POS_W-1:0]    total_q, total_d;
	logic [HDR_W-1:0]    hdr_end_q, hdr_end_d;
	logic                video_q, video_d;
	logic                pts_flag_q, pts_flag_d;
	logic [PTS_W-1:0]    pts_q, pts_d;
	logic                first_q, first_d;

	logic [POS_W:0]      pos_inc;
	logic [RECENT_W-1:0] recent_shift;
	logic [POS_W-1:0]    len_sum;

	assign pos_inc      = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
	assign recent_shift = {recent_q[RECENT_W-9:0], byte_in};
	assign len_sum      = {1'b0, total_q[15:8], byte_in} + PES_HDR_BYTES;

	always_comb begin
		phase_d    = phase_q;
		recent_d   = recent_q;
		code_d     = code_q;
		pos_d      = pos_q;
		total_d    = total_q;
		hdr_end_d  = hdr_end_q;
		video_d    = video_q;
		pts_flag_d = pts_flag_q;
		pts_d      = pts_q;
		first_d    = first_q;
		emit       = 1'b0;

		case (phase_q)
			PH_HUNT: begin
				recent_d = recent_shift;
				if (recent_shift == START_CODE) begin
					phase_d = PH_CODE;
				end
			end
			PH_CODE: begin
				code_d = byte_in;
				pos_d  = POS_CODE_DONE;
				if (byte_in == ID_PACK) begin
					total_d = PACK_LEN;
					phase_d = PH_BODY;
				end else if (byte_in == ID_PROG_END || byte_in < ID_FIRST_LEN) begin
					phase_d  = PH_HUNT;
					recent_d = RECENT_IDLE;
				end else begin
					phase_d = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				total_d = {1'b0, byte_in, 8'h00};
				pos_d   = POS_LEN_HI;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				total_d    = len_sum;
				pos_d      = POS_LEN_LO;
				hdr_end_d  = '0;
				video_d    = 1'b0;
				pts_flag_d = 1'b0;
				pts_d      = '0;
				first_d    = 1'b1;
				if (len_sum == PES_HDR_BYTES) begin
					phase_d  = PH_HUNT;
					recent_d = RECENT_IDLE;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				if (code_q == ID_PACK) begin
					// stuffing count sits in the low three bits of the last fixed byte
					if (pos_q == POS_PTS_4) begin
						total_d = PACK_LEN + {{(POS_W-3){1'b0}}, byte_in[2:0]};
					end
				end else begin
					if (pos_q == POS_LEN_LO) begin
						video_d = code_q >= ID_VIDEO_LO && code_q <= ID_VIDEO_HI &&
						          total_q >= MIN_VIDEO_LEN &&
						          (byte_in & MPEG2_MASK) == MPEG2_MARK;
					end else if (video_q && pos_q == POS_HDR_FLAGS) begin
						pts_flag_d = byte_in[7];
					end else if (video_q && pos_q == POS_HDR_LEN) begin
						hdr_end_d  = HDR_BASE + {1'b0, byte_in};
						pts_flag_d = pts_flag_q && byte_in >= MIN_PTS_HDR &&
						             total_q >= MIN_PTS_LEN;
					end else if (video_q && pts_flag_q) begin
						// assemble the timestamp, dropping marker bits
						case (pos_q)
							POS_PTS_0: pts_d[32:30] = pts_q[32:30] | byte_in[3:1];
							POS_PTS_1: pts_d[29:22] = pts_q[29:22] | byte_in;
							POS_PTS_2: pts_d[21:15] = pts_q[21:15] | byte_in[7:1];
							POS_PTS_3: pts_d[14:7]  = pts_q[14:7] | byte_in;
							POS_PTS_4: pts_d[6:0]   = pts_q[6:0] | byte_in[7:1];
							default:   pts_d = pts_q;
						endcase
					end
					if (video_q && pos_q >= POS_PTS_0 &&
					    pos_q >= {{(POS_W-HDR_W){1'b0}}, hdr_end_q} && pos_q < total_q) begin
						emit    = 1'b1;
						first_d = 1'b0;
					end
				end
				pos_d = pos_inc[POS_W-1:0];
				if (pos_inc >= {1'b0, total_d}) begin
					phase_d  = PH_HUNT;
					recent_d = RECENT_IDLE;
				end
			end
			default: begin
				phase_d  = PH_HUNT;
				recent_d = RECENT_IDLE;
			end
		endcase
	end

	always_comb begin
		result.payload_byte = byte_in;
		result.chunk_first  = first_q;
		result.chunk_last   = (pos_inc == {1'b0, total_q});
		result.pts_present  = pts_flag_q;
		result.pts          = pts_flag_q ? pts_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			recent_q   <= RECENT_IDLE;
			code_q     <= '0;
			pos_q      <= '0;
			total_q    <= '0;
			hdr_end_q  <= '0;
			video_q    <= 1'b0;
			pts_flag_q <= 1'b0;
			pts_q      <= '0;
			first_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			recent_q   <= recent_d;
			code_q     <= code_d;
			pos_q      <= pos_d;
			total_q    <= total_d;
			hdr_end_q  <= hdr_end_d;
			video_q    <= video_d;
			pts_flag_q <= pts_flag_d;
			pts_q      <= pts_d;
			first_q    <= first_d;
		end
	end

endmodule

/* sv/psvd_out_reg.sv */
`timescale 1ns / 1ps
// Result register on the output channel: holds one payload transaction until
// the receiver takes it. Depends on psvd_pkg.
module psvd_out_reg import psvd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  psvd_result_t data_in,
	output logic         can_load,
	output logic         valid,
	input  logic         ready,
	output psvd_result_t data_out
);

	logic         valid_q;
	psvd_result_t data_q;

	assign can_load = !valid_q || ready;
	assign valid    = valid_q;
	assign data_out = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= data_in;
		end
	end

endmodule

/* sv/program_stream_video_demux_unit.sv */
`timescale 1ns / 1ps
// Top level of the program stream video demux: input register, parser and
// result register. Depends on psvd_pkg, psvd_parser and psvd_out_reg.
//
// Usage:
//   Feed the program stream one byte per transaction on in_byte with
//   in_valid / in_ready. Each byte of video PES payload (stream ids E0..EF
//   with an MPEG-2 header) comes out as one transaction on out_valid /
//   out_ready, with chunk_first and chunk_last marking the first and last
//   payload bytes of a packet and pts_present / pts giving the packet's
//   timestamp (zero when absent). Pack headers, short start codes and other
//   packets produce no output.
//   Path: an accepted byte waits in the input register, is parsed
//   when the parser steps and its payload transaction is registered in
//   the result register. Throughput: one byte per cycle while the result
//   register can load, set by the combinational parse step.
//   Stall: while the result register holds an untaken transaction, the
//   parser holds; an empty input register still takes one more byte, then
//   in_ready stays low until out_ready frees the result register.
//   Reset: arst_n clears both registers' valid flags and returns the parser
//   to hunting for a start code with an all-ones byte history.
module program_stream_video_demux_unit import psvd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 chunk_first,
	output logic                 chunk_last,
	output logic                 pts_present,
	output logic [PTS_W-1:0]     pts
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              step;
	logic              emit;
	psvd_result_t      parse_res;
	psvd_result_t      out_res;

	// Advance the parser only when the result register can take its output.
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register: hold the byte until the parser consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	psvd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.emit    (emit),
		.result  (parse_res)
	);

	// Load a transaction only for a payload byte; drop non-payload steps.
	psvd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && emit),
		.data_in  (parse_res),
		.can_load (advance),
		.valid    (out_valid),
		.ready    (out_ready),
		.data_out (out_res)
	);

	assign payload_byte = out_res.payload_byte;
	assign chunk_first  = out_res.chunk_first;
	assign chunk_last   = out_res.chunk_last;
	assign pts_present  = out_res.pts_present;
	assign pts          = out_res.pts;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for program_stream_video_demux_unit: drives program stream
// bytes, predicts every video payload transaction and compares it field by field.
// Depends on psvd_pkg and the program_stream_video_demux_unit RTL.
module testbench;
	import psvd_pkg::*;

	localparam int CLK_HALF_NS   = 5;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int RANDOM_BYTES  = 400;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_PCT      = 13;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] payload_byte;
	logic              chunk_first;
	logic              chunk_last;
	logic              pts_present;
	logic [PTS_W-1:0]  pts;

	program_stream_video_demux_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.chunk_first  (chunk_first),
		.chunk_last   (chunk_last),
		.pts_present  (pts_present),
		.pts          (pts)
	);

	// Free-running clock, 10 ns period.
	initial begin
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Hard stop: a correct run ends long before this.
	initial begin
		#(TIMEOUT_NS);
		$display("program_stream_video_demux_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shared knobs and bookkeeping
	// ------------------------------------------------------------------
	int unsigned  src_idle_pct = IDLE_PCT;   // sender idles in this share of cycles
	int unsigned  sink_stall_pct = IDLE_PCT; // receiver stalls in this share of cycles
	bit           sink_hold_req = 1'b0;      // ask the receiver for one long hold-off
	int unsigned  sink_hold_left = 0;
	bit           fill_start_codes = 1'b0;   // pad bodies with 00 00 01 B9 instead of noise
	int unsigned  bytes_sent = 0;
	int unsigned  mismatch_count = 0;

	psvd_result_t video_payload_expected[$];

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the parser
	// ------------------------------------------------------------------
	logic [RECENT_W-1:0] hunt_window;
	psvd_phase_t         parse_st;
	logic [7:0]          cur_stream_id;
	logic [POS_W-1:0]    elem_pos;
	logic [POS_W-1:0]    elem_len;
	logic [HDR_W-1:0]    hdr_end_pos;
	bit                  in_video;
	bit                  ts_flag;
	logic [PTS_W-1:0]    ts_acc;
	bit                  first_due;

	task reset_demux_model;
		hunt_window   = RECENT_IDLE;
		parse_st      = PH_HUNT;
		cur_stream_id = '0;
		elem_pos      = '0;
		elem_len      = '0;
		hdr_end_pos   = '0;
		in_video      = 1'b0;
		ts_flag       = 1'b0;
		ts_acc        = '0;
		first_due     = 1'b0;
	endtask

	// Close the current element: hunt again with a clean byte history,
	// so nothing seen inside the element can form a start code.
	task end_element;
		parse_st    = PH_HUNT;
		hunt_window = RECENT_IDLE;
	endtask

	// Advance the parser copy by one accepted byte and queue the payload
	// transaction it produces, if any.
	task predict_video_payload(input logic [7:0] b);
		psvd_result_t r;
		case (parse_st)
			PH_HUNT: begin
				hunt_window = {hunt_window[RECENT_W-9:0], b};
				if (hunt_window == START_CODE)
					parse_st = PH_CODE;
			end
			PH_CODE: begin
				cur_stream_id = b;
				elem_pos      = POS_CODE_DONE;
				if (b == ID_PACK) begin
					elem_len = PACK_LEN;
					parse_st = PH_BODY;
				end else if (b == ID_PROG_END || b < ID_FIRST_LEN) begin
					// short codes carry nothing past the id byte
					end_element();
				end else begin
					parse_st = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				elem_len = {1'b0, b, 8'h00};
				elem_pos = POS_LEN_HI;
				parse_st = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				elem_len    = {1'b0, elem_len[15:8], b} + PES_HDR_BYTES;
				elem_pos    = POS_LEN_LO;
				hdr_end_pos = '0;
				in_video    = 1'b0;
				ts_flag     = 1'b0;
				ts_acc      = '0;
				first_due   = 1'b1;
				if (elem_len == PES_HDR_BYTES)
					end_element();
				else
					parse_st = PH_BODY;
			end
			PH_BODY: begin
				if (cur_stream_id == ID_PACK) begin
					// last fixed pack byte carries the stuffing count
					if (elem_pos == POS_PTS_4)
						elem_len = PACK_LEN + {{(POS_W-3){1'b0}}, b[2:0]};
				end else begin
					if (elem_pos == POS_LEN_LO) begin
						in_video = cur_stream_id >= ID_VIDEO_LO && cur_stream_id <= ID_VIDEO_HI &&
							elem_len >= MIN_VIDEO_LEN && (b & MPEG2_MASK) == MPEG2_MARK;
					end else if (in_video && elem_pos == POS_HDR_FLAGS) begin
						ts_flag = b[7];
					end else if (in_video && elem_pos == POS_HDR_LEN) begin
						hdr_end_pos = HDR_BASE + {1'b0, b};
						ts_flag = ts_flag && b >= MIN_PTS_HDR && elem_len >= MIN_PTS_LEN;
					end else if (in_video && ts_flag) begin
						case (elem_pos)
							POS_PTS_0: ts_acc[32:30] = ts_acc[32:30] | b[3:1];
							POS_PTS_1: ts_acc[29:22] = ts_acc[29:22] | b;
							POS_PTS_2: ts_acc[21:15] = ts_acc[21:15] | b[7:1];
							POS_PTS_3: ts_acc[14:7]  = ts_acc[14:7] | b;
							POS_PTS_4: ts_acc[6:0]   = ts_acc[6:0] | b[7:1];
							default: ;
						endcase
					end
					if (in_video && elem_pos >= POS_PTS_0 && elem_pos >= hdr_end_pos &&
							elem_pos < elem_len) begin
						r.payload_byte = b;
						r.chunk_first  = first_due;
						r.chunk_last   = (elem_pos + 17'd1 == elem_len);
						r.pts_present  = ts_flag;
						r.pts          = ts_flag ? ts_acc : '0;
						video_payload_expected.push_back(r);
						first_due = 1'b0;
					end
				end
				if (elem_pos + 17'd1 >= elem_len)
					end_element();
				elem_pos = elem_pos + 17'd1;
			end
			default: end_element();
		endcase
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (sink_hold_req) begin
			sink_hold_req  = 1'b0;
			sink_hold_left = HOLD_OFF_LEN;
		end
		if (sink_hold_left > 0) begin
			sink_hold_left = sink_hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each output transaction with the oldest prediction
	// ------------------------------------------------------------------
	task check_field(input string name, input logic [PTS_W-1:0] want, input logic [PTS_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		psvd_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (video_payload_expected.size() == 0) begin
				$display("%0t ns: unexpected payload transaction, expected none, actual byte %0h",
					$time, payload_byte);
				mismatch_count++;
			end else begin
				want = video_payload_expected.pop_front();
				check_field("payload_byte", want.payload_byte, payload_byte);
				check_field("chunk_first", want.chunk_first, chunk_first);
				check_field("chunk_last", want.chunk_last, chunk_last);
				check_field("pts_present", want.pts_present, pts_present);
				check_field("pts", want.pts, pts);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus building blocks
	// ------------------------------------------------------------------

	// Offer one byte, idling first at random; hold valid and the byte until
	// the transaction is taken, then advance the predictor.
	task send_stream_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		predict_video_payload(b);
		bytes_sent++;
	endtask

	function logic [PTS_W-1:0] rand_pts();
		logic [PTS_W-1:0] t;
		t[31:0] = $urandom();
		t[32]   = $urandom_range(1);
		return t;
	endfunction

	task send_start_code(input logic [7:0] id);
		send_stream_byte(START_CODE[23:16]);
		send_stream_byte(START_CODE[15:8]);
		send_stream_byte(START_CODE[7:0]);
		send_stream_byte(id);
	endtask

	// Pack header: fixed part with random content, stuffing count in the
	// low bits of its last byte, then the stuffing itself.
	task send_pack(input logic [2:0] stuff);
		logic [7:0] r;
		int unsigned p;
		send_start_code(ID_PACK);
		for (p = POS_CODE_DONE; p < POS_PTS_4; p++)
			send_stream_byte($urandom_range(255));
		r = $urandom_range(255);
		send_stream_byte({r[7:3], stuff});
		for (p = 0; p < stuff; p++)
			send_stream_byte(8'hFF);
	endtask

	// Length-delimited packet. Header bytes come from the arguments, PTS
	// slots from ts with random marker bits, the rest is fill. Stop after
	// cut body bytes when cut is not negative.
	task send_pes(input logic [7:0] id, input logic [15:0] pes_len, input logic [7:0] flags1,
			input logic [7:0] flags2, input logic [7:0] hdr_len, input logic [PTS_W-1:0] ts,
			input int cut);
		int unsigned p;
		int unsigned last;
		logic [7:0] r;
		logic [7:0] b;
		send_start_code(id);
		send_stream_byte(pes_len[15:8]);
		send_stream_byte(pes_len[7:0]);
		last = pes_len + PES_HDR_BYTES;
		if (cut >= 0 && PES_HDR_BYTES + cut < last)
			last = PES_HDR_BYTES + cut;
		for (p = POS_LEN_LO; p < last; p++) begin
			r = $urandom_range(255);
			case (p)
				POS_LEN_LO:    b = flags1;
				POS_HDR_FLAGS: b = flags2;
				POS_HDR_LEN:   b = hdr_len;
				POS_PTS_0:     b = {r[7:4], ts[32:30], r[0]};
				POS_PTS_1:     b = ts[29:22];
				POS_PTS_2:     b = {ts[21:15], r[0]};
				POS_PTS_3:     b = ts[14:7];
				POS_PTS_4:     b = {ts[6:0], r[0]};
				default: begin
					if (!fill_start_codes)
						b = r;
					else if (p % 4 == 2)
						b = START_CODE[7:0];
					else if (p % 4 == 3)
						b = ID_PROG_END;
					else
						b = 8'h00;
				end
			endcase
			send_stream_byte(b);
		end
	endtask

	// Well-formed video packet with an MPEG-2 header.
	task send_video(input logic [7:0] id, input int hdr_len, input int payload_len,
			input bit pts_on, input logic [PTS_W-1:0] ts);
		logic [7:0] r;
		r = $urandom_range(255);
		send_pes(id, 3 + hdr_len + payload_len, {2'b10, r[5:0]}, {pts_on, r[6:0]},
			hdr_len, ts, -1);
	endtask

	// Stray bytes, heavy in zeros so partial start codes show up.
	task send_noise(input int n);
		logic [7:0] b;
		int i;
		for (i = 0; i < n; i++) begin
			b = $urandom_range(255);
			if ($urandom_range(2) == 0)
				b = 8'h00;
			send_stream_byte(b);
		end
	endtask

	// Video packet that is wrong in one of several ways.
	task send_broken_video;
		logic [7:0] id;
		logic [7:0] r;
		int unsigned hlen;
		int unsigned plen;
		id = ID_VIDEO_LO + $urandom_range(15);
		r  = $urandom_range(255);
		case ($urandom_range(4))
			0: begin
				// first header byte fails the MPEG-2 marker test
				if (r[7:6] == 2'b10)
					r[7:6] = 2'b11;
				send_pes(id, 3 + $urandom_range(12), r, 8'h80, 8'd5, rand_pts(), -1);
			end
			1: send_pes(id, $urandom_range(2), {2'b10, r[5:0]}, r, r, rand_pts(), -1);
			2: begin
				// header leaves no room for payload bytes in the packet
				hlen = $urandom_range(8, 40);
				send_pes(id, 3 + $urandom_range(hlen), {2'b10, r[5:0]}, r, hlen, rand_pts(), -1);
			end
			3: send_video(id, $urandom_range(4), $urandom_range(1, 12), 1'b1, rand_pts());
			default: begin
				// cut short; the following element feeds the rest of it
				plen = $urandom_range(1, 16);
				send_pes(id, 8 + plen, {2'b10, r[5:0]}, 8'h80, 8'd5, rand_pts(),
					$urandom_range(8 + plen - 1));
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Pack headers with both stuffing extremes, program end and other short
	// codes, then a small video packet to show the parser is back in sync.
	task test_pack_and_short_codes;
		send_pack(3'd0);
		send_pack(3'd7);
		send_start_code(ID_PROG_END);
		send_start_code(8'h00);
		send_start_code(8'hB0);
		send_video(ID_VIDEO_LO, 0, 2, 1'b0, '0);
	endtask

	// Timestamp extremes, packets without PTS, a one-byte payload.
	task test_video_timestamps;
		send_video(ID_VIDEO_LO, 5, 4, 1'b1, '0);
		send_video(ID_VIDEO_HI, 5, 4, 1'b1, {PTS_W{1'b1}});
		send_video(ID_VIDEO_LO + 3, 8, 6, 1'b1, rand_pts());
		send_video(ID_VIDEO_LO + 9, 5, 3, 1'b0, rand_pts());
		send_video(ID_VIDEO_HI, 0, 1, 1'b0, '0);
	endtask

	// Empty and short packets, non-MPEG-2 headers, header past packet end,
	// PTS flag with a short header or short packet, non-video stream ids,
	// start codes hidden in a payload.
	task test_video_corner_cases;
		send_pes(ID_VIDEO_LO, 16'd0, 8'h80, 8'h80, 8'd5, '0, -1);
		send_pes(ID_VIDEO_LO, 16'd1, 8'h80, 8'h80, 8'd5, '0, -1);
		send_pes(ID_VIDEO_LO, 16'd2, 8'h80, 8'h80, 8'd5, '0, -1);
		send_pes(ID_VIDEO_LO, 16'd3, 8'h80, 8'h00, 8'd0, '0, -1);
		send_pes(ID_VIDEO_HI, 16'd12, 8'h40, 8'h80, 8'd5, rand_pts(), -1);
		send_pes(ID_VIDEO_HI, 16'd12, 8'hC0, 8'h80, 8'd5, rand_pts(), -1);
		send_pes(ID_VIDEO_HI, 16'd12, 8'h0F, 8'h80, 8'd5, rand_pts(), -1);
		send_pes(ID_VIDEO_LO, 16'd10, 8'h80, 8'h00, 8'd20, '0, -1);
		send_pes(ID_VIDEO_LO, 16'd10, 8'h80, 8'h00, 8'd7, '0, -1);
		send_video(ID_VIDEO_LO, 4, 5, 1'b1, rand_pts());
		send_pes(ID_VIDEO_LO, 16'd7, 8'h80, 8'h80, 8'd5, rand_pts(), -1);
		send_video(MPEG2_MASK, 5, 4, 1'b1, rand_pts());
		send_video(8'hBD, 0, 4, 1'b0, '0);
		send_video(8'hDF, 0, 4, 1'b0, '0);
		send_video(8'hF0, 0, 4, 1'b0, '0);
		send_video(ID_FIRST_LEN, 0, 4, 1'b0, '0);
		fill_start_codes = 1'b1;
		send_video(ID_VIDEO_LO + 1, 0, 16, 1'b0, '0);
		send_video(8'hC5, 0, 8, 1'b0, '0);
		fill_start_codes = 1'b0;
		send_video(ID_VIDEO_LO + 2, 0, 3, 1'b0, '0);
	endtask

	// Extra leading zeros, a start code that overlaps a short code, and
	// plain garbage before a good packet.
	task test_resync_after_noise;
		send_stream_byte(8'h12);
		send_stream_byte(8'h00);
		send_stream_byte(8'h00);
		send_video(ID_VIDEO_LO + 4, 5, 3, 1'b1, rand_pts());
		send_stream_byte(8'h00);
		send_stream_byte(8'h00);
		send_stream_byte(8'h01);
		send_stream_byte(8'h00);
		send_stream_byte(8'h00);
		send_stream_byte(8'h01);
		send_stream_byte(ID_VIDEO_LO);
		send_noise(12);
		send_video(ID_VIDEO_LO + 5, 0, 2, 1'b0, '0);
	endtask

	// Hold off the receiver for a long stretch while a big packet streams
	// in; the block fills up and drops in_ready until the hold ends.
	task test_output_backpressure;
		sink_hold_req = 1'b1;
		send_video(ID_VIDEO_LO + 6, 5, 120, 1'b1, rand_pts());
		send_video(ID_VIDEO_LO + 6, 0, 10, 1'b0, '0);
	endtask

	// Length field above 255: both length bytes count and the position
	// counter runs past the low byte range.
	task test_long_packet;
		send_pes(ID_VIDEO_LO + 7, 16'h0123, 8'h8F, 8'h80, MIN_PTS_HDR, rand_pts(), -1);
	endtask

	// Mostly well-formed elements with random content, mixed with broken
	// packets and noise; a quiet stretch in the middle has no idling.
	task test_random_stream;
		int unsigned start_cnt;
		int unsigned kind;
		int unsigned hlen;
		bit pts_on;
		logic [7:0] id;
		logic [7:0] r;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < RANDOM_BYTES) begin
			if (bytes_sent - start_cnt >= 100 && bytes_sent - start_cnt < 300) begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end else begin
				src_idle_pct   = IDLE_PCT;
				sink_stall_pct = IDLE_PCT;
			end
			fill_start_codes = ($urandom_range(9) == 0);
			kind = $urandom_range(99);
			r    = $urandom_range(255);
			if (kind < 50) begin
				pts_on = ($urandom_range(99) < 60);
				hlen   = pts_on ? 5 + $urandom_range(3) : $urandom_range(4);
				send_video(ID_VIDEO_LO + $urandom_range(15), hlen, $urandom_range(24), pts_on,
					rand_pts());
			end else if (kind < 62) begin
				send_broken_video();
			end else if (kind < 72) begin
				send_pack($urandom_range(7));
			end else if (kind < 82) begin
				id = $urandom_range(ID_FIRST_LEN, 8'hFF);
				if (id >= ID_VIDEO_LO && id <= ID_VIDEO_HI)
					id = id ^ 8'h10;
				send_pes(id, $urandom_range(20), r, r, $urandom_range(255), rand_pts(), -1);
			end else if (kind < 90) begin
				send_start_code($urandom_range(ID_PROG_END));
			end else begin
				send_noise($urandom_range(1, 8));
			end
		end
		fill_start_codes = 1'b0;
		src_idle_pct     = IDLE_PCT;
		sink_stall_pct   = IDLE_PCT;
	endtask

	// Stream ends inside a video packet: payload comes out with no last mark.
	task test_truncated_tail;
		send_pes(ID_VIDEO_LO + 8, 16'd40, 8'h80, 8'h80, 8'd5, rand_pts(), 20);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		reset_demux_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_pack_and_short_codes();
		test_video_timestamps();
		test_video_corner_cases();
		test_resync_after_noise();
		test_output_backpressure();
		test_long_packet();
		test_random_stream();
		test_truncated_tail();

		// Drop valid, wait for every predicted transaction, then keep
		// watching for anything extra.
		@(negedge clk);
		in_valid <= 1'b0;
		while (video_payload_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("program_stream_video_demux_unit test passed");
		else
			$display("program_stream_video_demux_unit test failed");
		$finish;
	end

endmodule
